>>> src/uleb_pkg.sv
package uleb_pkg;

  // Buffer geometry.
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned POS_W    = ADDR_W + 1;

  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CAP = POS_W'(CAPACITY);

  // Field widths of one word on either side.
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POSO_W  = 9;
  localparam int unsigned IN_DW   = 32;
  localparam int unsigned OUT_DW  = 32;

  // Command kinds as they arrive on the input side.
  localparam logic [KIND_W-1:0] KIND_LEFT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RIGHT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BKSP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd5;

  // Decoded operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_LEFT,
    OP_RIGHT,
    OP_BKSP,
    OP_DEL,
    OP_INS,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic [3:0][BYTE_W-1:0]      enc;    // encoded bytes, first byte in entry 0
    logic [1:0]                  nlast;  // number of encoded bytes minus one
    logic [INDEX_W-1:0]          index;
  } cmd_t;

  typedef struct packed {
    logic                ok;
    logic [POS_W-1:0]    cursor;
    logic [POS_W-1:0]    length;
    logic [BYTE_W-1:0]   read_data;
  } res_t;

  // Sequencer states of the back end.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_L_RD,
    ST_L_CHK,
    ST_N_RD,
    ST_N_CHK,
    ST_SH_DN,
    ST_SH_UP,
    ST_INS_WR,
    ST_RD_CHK,
    ST_DONE
  } back_st_e;

endpackage

>>> src/utf8_line_edit_buffer_unit.sv
// The input register and the two-entry queue pass commands to the back end, which runs one
// command at a time: a read does one memory read, left and right scan the text byte by byte, and
// refused or spare commands go straight to the result. Backspace and delete move the tail down
// after the scan; each inserted byte first moves the tail up, then is written. The result is then
// loaded into the output register; the back end takes a new command only after that load.
// Reset: asynchronous, active low; clears cursor, length and handshake state, not the text memory.
module utf8_line_edit_buffer_unit
  import uleb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [IN_DW-1:0]   s_axis_tdata_i,   // codepoint[20:0], index[28:21], zeros
  input  logic [KIND_W-1:0]  s_axis_tuser_i,   // kind[2:0]
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [OUT_DW-1:0]  m_axis_tdata_o    // ok[0], cursor[9:1], length[18:10],
                                               // read_data[26:19], zeros
);

  logic  f_valid;
  logic  f_ready;
  cmd_t  f_cmd;
  logic  q_valid;
  logic  q_pop;
  cmd_t  q_cmd;
  res_t  res;

  uleb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .kind_i      (s_axis_tuser_i),
    .codepoint_i (s_axis_tdata_i[CP_W-1:0]),
    .index_i     (s_axis_tdata_i[CP_W+INDEX_W-1:CP_W]),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  uleb_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_cmd_o    (q_cmd)
  );

  uleb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .cmd_i       (q_cmd),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // Pack the result word.
  assign m_axis_tdata_o = {
    {(OUT_DW - 1 - 2*POSO_W - BYTE_W){1'b0}},
    res.read_data,
    POSO_W'(res.length),
    POSO_W'(res.cursor),
    res.ok
  };

endmodule

>>> src/uleb_front.sv
module uleb_front
  import uleb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [CP_W-1:0]     codepoint_i,
  input  logic [INDEX_W-1:0]  index_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output cmd_t                cmd_o
);

  logic  vld_q;
  cmd_t  cmd_q;
  cmd_t  cmd_d;

  // Decode the kind and encode the codepoint into UTF-8 bytes.
  always_comb begin
    cmd_d       = '0;
    cmd_d.index = index_i;
    unique case (kind_i)
      KIND_LEFT:   cmd_d.op = OP_LEFT;
      KIND_RIGHT:  cmd_d.op = OP_RIGHT;
      KIND_BKSP:   cmd_d.op = OP_BKSP;
      KIND_DELETE: cmd_d.op = OP_DEL;
      KIND_INSERT: cmd_d.op = OP_INS;
      KIND_READ:   cmd_d.op = OP_READ;
      default:     cmd_d.op = OP_NOP;
    endcase
    if (codepoint_i < 21'h80) begin
      cmd_d.enc[0] = codepoint_i[7:0];
      cmd_d.nlast  = 2'd0;
    end else if (codepoint_i < 21'h800) begin
      cmd_d.enc[0] = {3'b110, codepoint_i[10:6]};
      cmd_d.enc[1] = {2'b10, codepoint_i[5:0]};
      cmd_d.nlast  = 2'd1;
    end else if (codepoint_i < 21'h10000) begin
      cmd_d.enc[0] = {4'b1110, codepoint_i[15:12]};
      cmd_d.enc[1] = {2'b10, codepoint_i[11:6]};
      cmd_d.enc[2] = {2'b10, codepoint_i[5:0]};
      cmd_d.nlast  = 2'd2;
    end else begin
      cmd_d.enc[0] = {5'b11110, codepoint_i[20:18]};
      cmd_d.enc[1] = {2'b10, codepoint_i[17:12]};
      cmd_d.enc[2] = {2'b10, codepoint_i[11:6]};
      cmd_d.enc[3] = {2'b10, codepoint_i[5:0]};
      cmd_d.nlast  = 2'd3;
    end
  end

  assign in_ready_o  = !vld_q || cmd_ready_i;
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  // Holding register for one decoded word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      vld_q <= 1'b1;
    end else if (cmd_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

>>> src/uleb_fifo.sv
module uleb_fifo
  import uleb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  push_ready_o,
  input  cmd_t  push_cmd_i,
  output logic  pop_valid_o,
  input  logic  pop_i,
  output cmd_t  pop_cmd_o
);

  cmd_t        ent_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        do_push;
  logic        do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = ent_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Pointers and fill count of the two-entry queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> src/uleb_back.sv
module uleb_back
  import uleb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cmd_valid_i,
  output logic  cmd_pop_o,
  input  cmd_t  cmd_i,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output res_t  res_o
);

  // Text memory, one write and one registered read per cycle.
  logic [BYTE_W-1:0] mem_q [CAPACITY];
  logic [BYTE_W-1:0] rdata_q;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;

  back_st_e          st_q, st_d;
  cmd_t              cmd_q, cmd_d;
  logic [POS_W-1:0]  cur_q, cur_d;
  logic [POS_W-1:0]  len_q, len_d;
  logic [POS_W-1:0]  p_q, p_d;
  logic [POS_W-1:0]  src_q, src_d;
  logic [POS_W-1:0]  gap_q, gap_d;
  logic [ADDR_W-1:0] wa_q, wa_d;
  logic              pend_q, pend_d;
  logic              lead_q, lead_d;
  logic [1:0]        need_q, need_d;
  logic [1:0]        j_q, j_d;
  logic [1:0]        bi_q, bi_d;
  logic              ok_q, ok_d;
  logic [BYTE_W-1:0] rd_q, rd_d;
  logic              res_vld_q;
  res_t              res_q;
  logic              res_load;

  logic              is_cont;
  logic [1:0]        lead_need;
  logic              nx_fin;
  logic [POS_W-1:0]  nx_end;

  assign is_cont = (rdata_q[7:6] == 2'b10);

  // Continuation bytes a lead byte asks for.
  always_comb begin
    if (rdata_q[7] == 1'b0) begin
      lead_need = 2'd0;
    end else if (rdata_q[7:5] == 3'b110) begin
      lead_need = 2'd1;
    end else if (rdata_q[7:4] == 4'b1110) begin
      lead_need = 2'd2;
    end else if (rdata_q[7:3] == 5'b11110) begin
      lead_need = 2'd3;
    end else begin
      lead_need = 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Command sequencer.
  always_comb begin
    st_d      = st_q;
    cmd_d     = cmd_q;
    cur_d     = cur_q;
    len_d     = len_q;
    p_d       = p_q;
    src_d     = src_q;
    gap_d     = gap_q;
    wa_d      = wa_q;
    pend_d    = pend_q;
    lead_d    = lead_q;
    need_d    = need_q;
    j_d       = j_q;
    bi_d      = bi_q;
    ok_d      = ok_q;
    rd_d      = rd_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    cmd_pop_o = 1'b0;
    res_load  = 1'b0;
    nx_fin    = 1'b0;
    nx_end    = cur_q + POS_ONE;

    unique case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          ok_d      = 1'b0;
          rd_d      = '0;
          st_d      = ST_DONE;
          case (cmd_i.op) inside
            OP_LEFT, OP_BKSP: begin
              if (cur_q != '0) begin
                p_d  = cur_q - POS_ONE;
                st_d = ST_L_RD;
              end
            end
            OP_RIGHT, OP_DEL: begin
              if (cur_q < len_q) begin
                p_d    = cur_q;
                lead_d = 1'b1;
                st_d   = ST_N_RD;
              end
            end
            OP_INS: begin
              bi_d = 2'd0;
              if (len_q < POS_CAP) begin
                src_d  = len_q;
                pend_d = 1'b0;
                st_d   = ST_SH_UP;
              end
            end
            OP_READ: begin
              if (POS_W'(cmd_i.index) < len_q) begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(cmd_i.index);
                st_d      = ST_RD_CHK;
              end
            end
            default: begin
              st_d = ST_DONE;
            end
          endcase
        end
      end

      // Backward scan over continuation bytes.
      ST_L_RD: begin
        mem_re    = 1'b1;
        mem_raddr = p_q[ADDR_W-1:0];
        st_d      = ST_L_CHK;
      end

      ST_L_CHK: begin
        if (p_q != '0 && is_cont) begin
          p_d  = p_q - POS_ONE;
          st_d = ST_L_RD;
        end else begin
          cur_d = p_q;
          ok_d  = 1'b1;
          if (cmd_q.op == OP_LEFT) begin
            st_d = ST_DONE;
          end else begin
            gap_d  = cur_q - p_q;
            src_d  = cur_q;
            pend_d = 1'b0;
            st_d   = ST_SH_DN;
          end
        end
      end

      // Forward decode of one codepoint.
      ST_N_RD: begin
        mem_re    = 1'b1;
        mem_raddr = p_q[ADDR_W-1:0];
        st_d      = ST_N_CHK;
      end

      ST_N_CHK: begin
        if (lead_q) begin
          lead_d = 1'b0;
          need_d = lead_need;
          j_d    = 2'd0;
          if (lead_need == 2'd0 || (cur_q + POS_ONE) >= len_q) begin
            nx_fin = 1'b1;
          end else begin
            p_d  = cur_q + POS_ONE;
            st_d = ST_N_RD;
          end
        end else if (is_cont) begin
          if (j_q + 2'd1 == need_q) begin
            nx_fin = 1'b1;
            nx_end = p_q + POS_ONE;
          end else if ((p_q + POS_ONE) < len_q) begin
            j_d  = j_q + 2'd1;
            p_d  = p_q + POS_ONE;
            st_d = ST_N_RD;
          end else begin
            nx_fin = 1'b1;
          end
        end else begin
          nx_fin = 1'b1;
        end
        if (nx_fin) begin
          ok_d = 1'b1;
          if (cmd_q.op == OP_RIGHT) begin
            cur_d = nx_end;
            st_d  = ST_DONE;
          end else begin
            gap_d  = nx_end - cur_q;
            src_d  = nx_end;
            pend_d = 1'b0;
            st_d   = ST_SH_DN;
          end
        end
      end

      // Move the tail down over a gap, one byte per cycle.
      ST_SH_DN: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wa_q;
          mem_wdata = rdata_q;
        end
        if (src_q < len_q) begin
          mem_re    = 1'b1;
          mem_raddr = src_q[ADDR_W-1:0];
          wa_d      = ADDR_W'(src_q - gap_q);
          src_d     = src_q + POS_ONE;
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            len_d = len_q - gap_q;
            st_d  = ST_DONE;
          end
        end
      end

      // Move the tail up by one byte to open a slot at the cursor.
      ST_SH_UP: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wa_q;
          mem_wdata = rdata_q;
        end
        if (src_q > cur_q) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(src_q - POS_ONE);
          wa_d      = src_q[ADDR_W-1:0];
          src_d     = src_q - POS_ONE;
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            st_d = ST_INS_WR;
          end
        end
      end

      ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q[ADDR_W-1:0];
        mem_wdata = cmd_q.enc[bi_q];
        cur_d     = cur_q + POS_ONE;
        len_d     = len_q + POS_ONE;
        if (bi_q == cmd_q.nlast) begin
          ok_d = 1'b1;
          st_d = ST_DONE;
        end else if ((len_q + POS_ONE) >= POS_CAP) begin
          ok_d = 1'b0;
          st_d = ST_DONE;
        end else begin
          bi_d   = bi_q + 2'd1;
          src_d  = len_q + POS_ONE;
          pend_d = 1'b0;
          st_d   = ST_SH_UP;
        end
      end

      ST_RD_CHK: begin
        rd_d = rdata_q;
        ok_d = 1'b1;
        st_d = ST_DONE;
      end

      ST_DONE: begin
        if (!res_vld_q || res_ready_i) begin
          res_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cur_q     <= '0;
      len_q     <= '0;
      pend_q    <= 1'b0;
      lead_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cur_q  <= cur_d;
      len_q  <= len_d;
      pend_q <= pend_d;
      lead_q <= lead_d;
      if (res_load) begin
        res_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    p_q    <= p_d;
    src_q  <= src_d;
    gap_q  <= gap_d;
    wa_q   <= wa_d;
    need_q <= need_d;
    j_q    <= j_d;
    bi_q   <= bi_d;
    ok_q   <= ok_d;
    rd_q   <= rd_d;
    if (res_load) begin
      res_q.ok        <= ok_q;
      res_q.cursor    <= cur_q;
      res_q.length    <= len_q;
      res_q.read_data <= rd_q;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

>>> src/uleb_checker.sv
module uleb_checker
  import uleb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  input  logic [OUT_DW-1:0]  m_axis_tdata_o
);

  logic              ok;
  logic [POSO_W-1:0] cursor;
  logic [POSO_W-1:0] length;
  logic [BYTE_W-1:0] read_data;

  assign ok        = m_axis_tdata_o[0];
  assign cursor    = m_axis_tdata_o[POSO_W:1];
  assign length    = m_axis_tdata_o[2*POSO_W:POSO_W+1];
  assign read_data = m_axis_tdata_o[2*POSO_W+BYTE_W:2*POSO_W+1];

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // The cursor never passes the end of the text, and the text never passes capacity.
  a_pos_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> cursor <= length && length <= POSO_W'(CAPACITY))
    else $error("cursor or length out of order");

  // Read data only comes with a successful read.
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !ok |-> read_data == '0)
    else $error("read data without success");

endmodule

bind utf8_line_edit_buffer_unit uleb_checker u_uleb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
